@@ sv/fdic_pkg.sv @@
package fdic_pkg;

  // widths of the stream payloads
  localparam int VAL_W      = 32;
  localparam int IN_TDATA_W = 4 * VAL_W;
  localparam int OUT_TDATA_W = VAL_W;

  // number of steps of the wide square root (one result bit each)
  localparam int ROOT_STEPS = 32;

  // blocked code after reset: 1000000.0 in fixed point, clipped to 32 bits
  function automatic logic [VAL_W-1:0] inf_reset(input int frac_bits);
    logic [63:0] v;
    v = 64'd1000000 << frac_bits;
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[VAL_W-1:0];
  endfunction

endpackage

@@ sv/field_dstar_interpolated_cost.sv @@
// channel | dir | handshake               | payload
// in      | in  | in_tvalid / in_tready   | tdata: center_cost, adjacent_cost, g_a, g_b
//         |     |                         | tuser: a_is_diagonal
// out     | out | out_tvalid / out_tready | tdata: path_cost
// cfg     | in  | cfg_we                  | cfg_wdata: infinite_cost
//
// one item per cycle sustained while the output is not stalled; the pipeline runs from
// the accepting edge to out_tvalid through 42 + 2*FRAC_BITS register stages,
// set by the 32-step square root, the FRAC_BITS+2 step divider and the FRAC_BITS+1 step
// root of 1 + m*m, one step per register stage
// rst_n (synchronous) empties the pipeline and loads the blocked code 1000000.0
// a stall on the output freezes every stage at once; in_tready drops for that cycle
module field_dstar_interpolated_cost #(
  parameter int FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // center_cost [31:0], adjacent_cost [63:32], g_a [95:64], g_b [127:96]
  input  logic [fdic_pkg::IN_TDATA_W-1:0]   in_tdata,
  // a_is_diagonal [0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // path_cost [31:0]
  output logic [fdic_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic [fdic_pkg::VAL_W-1:0]        cfg_wdata
);
  import fdic_pkg::*;

  localparam int NW   = VAL_W + FRAC_BITS + 2;
  localparam int SW   = 2 * FRAC_BITS + 2;
  localparam int SQ0  = 3;
  localparam int DV0  = SQ0 + ROOT_STEPS;
  localparam int MST  = DV0 + FRAC_BITS + 2;
  localparam int R20  = MST + 2;
  localparam int PST  = R20 + FRAC_BITS + 1;
  localparam int NST  = PST + 2;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  typedef struct packed {
    logic                 done;
    logic [VAL_W-1:0]     res;
    logic [VAL_W-1:0]     c;
    logic [VAL_W-1:0]     e;
    logic [VAL_W-1:0]     g2;
    logic                 diag;
    logic [63:0]          sv;
    logic [63:0]          sr;
    logic [VAL_W-1:0]     dd;
    logic [NW-1:0]        rem;
    logic [FRAC_BITS:0]   q;
    logic                 ovf;
    logic [FRAC_BITS:0]   m;
    logic [SW-1:0]        r2v;
    logic [SW-1:0]        r2r;
    logic [63:0]          t1;
    logic [63:0]          t2;
  } rec_t;

  logic [VAL_W-1:0] inf_r;
  rec_t             stg_r   [NST];
  rec_t             stg_nxt [NST];
  logic [NST-1:0]   vld_r;
  logic             en;

  // global advance: the whole pipe holds while the output is stalled
  assign en        = !(vld_r[NST-1] && !out_tready);
  assign in_tready = en;
  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = stg_r[NST-1].res;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inf_r <= inf_reset(FRAC_BITS);
    end else if (cfg_we) begin
      inf_r <= cfg_wdata;
    end
  end

  genvar s;
  generate
    for (s = 0; s < NST; s++) begin : g_stg
      if (s == 0) begin : g_dec
        // decode: order neighbours, pick the case, settle blocked and straight results
        always_comb begin
          rec_t             nx;
          logic [VAL_W-1:0] c, b, ga, gb, g1, g2, mc, f;
          logic [VAL_W:0]   st;
          nx = '0;
          c  = in_tdata[VAL_W-1:0];
          b  = in_tdata[2*VAL_W-1:VAL_W];
          ga = in_tdata[3*VAL_W-1:2*VAL_W];
          gb = in_tdata[4*VAL_W-1:3*VAL_W];
          g1 = in_tuser ? gb : ga;
          g2 = in_tuser ? ga : gb;
          mc = (c < b) ? c : b;
          f  = g1 - g2;
          st = {1'b0, mc} + {1'b0, g1};
          nx.c  = c;
          nx.g2 = g2;
          if (mc >= inf_r) begin
            nx.done = 1'b1;
            nx.res  = inf_r;
          end else if (g1 <= g2) begin
            nx.done = 1'b1;
            nx.res  = (st >= {1'b0, inf_r}) ? inf_r : st[VAL_W-1:0];
          end else if (f <= b) begin
            nx.diag = (c <= f);
            nx.e    = (c <= f) ? '0 : f;
          end else begin
            nx.diag = (c <= b);
            nx.e    = (c <= b) ? '0 : b;
          end
          stg_nxt[s] = nx;
        end
      end else if (s == 1) begin : g_sq
        // squares of c and e
        always_comb begin
          rec_t nx;
          nx    = stg_r[s-1];
          nx.sv = 64'(stg_r[s-1].c) * 64'(stg_r[s-1].c);
          nx.sr = 64'(stg_r[s-1].e) * 64'(stg_r[s-1].e);
          stg_nxt[s] = nx;
        end
      end else if (s == 2) begin : g_rad
        // radicand c*c - e*e
        always_comb begin
          rec_t nx;
          nx    = stg_r[s-1];
          nx.sv = stg_r[s-1].sv - stg_r[s-1].sr;
          nx.sr = '0;
          stg_nxt[s] = nx;
        end
      end else if (s < DV0) begin : g_root
        // one step of the wide integer square root
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (s - SQ0));
        always_comb begin
          rec_t nx;
          nx = stg_r[s-1];
          if (stg_r[s-1].sv >= stg_r[s-1].sr + BIT) begin
            nx.sv = stg_r[s-1].sv - (stg_r[s-1].sr + BIT);
            nx.sr = (stg_r[s-1].sr >> 1) + BIT;
          end else begin
            nx.sr = stg_r[s-1].sr >> 1;
          end
          stg_nxt[s] = nx;
        end
      end else if (s == DV0) begin : g_dvi
        // divider setup and quotient overflow check
        always_comb begin
          rec_t             nx;
          logic [VAL_W-1:0] d;
          nx    = stg_r[s-1];
          d     = (stg_r[s-1].sr[VAL_W-1:0] == '0) ? VAL_W'(1) : stg_r[s-1].sr[VAL_W-1:0];
          nx.dd = d;
          nx.rem = NW'({stg_r[s-1].e, {FRAC_BITS{1'b0}}});
          nx.q   = '0;
          nx.ovf = nx.rem >= (NW'(d) << (FRAC_BITS + 1));
          stg_nxt[s] = nx;
        end
      end else if (s < MST) begin : g_div
        // one quotient bit of (e << F) / d
        localparam int J = FRAC_BITS - (s - DV0 - 1);
        always_comb begin
          rec_t          nx;
          logic [NW-1:0] dsh;
          nx  = stg_r[s-1];
          dsh = NW'(stg_r[s-1].dd) << J;
          if (!stg_r[s-1].ovf && stg_r[s-1].rem >= dsh) begin
            nx.rem  = stg_r[s-1].rem - dsh;
            nx.q[J] = 1'b1;
          end
          stg_nxt[s] = nx;
        end
      end else if (s == MST) begin : g_m
        // ratio m clamped to one, one for the diagonal case
        always_comb begin
          rec_t nx;
          nx   = stg_r[s-1];
          nx.m = (stg_r[s-1].diag || stg_r[s-1].ovf || stg_r[s-1].q > ONE) ? ONE : stg_r[s-1].q;
          stg_nxt[s] = nx;
        end
      end else if (s == MST + 1) begin : g_mm
        // radicand 1 + m*m
        always_comb begin
          rec_t nx;
          nx     = stg_r[s-1];
          nx.r2v = (SW'(1) << (2 * FRAC_BITS)) + SW'(stg_r[s-1].m) * SW'(stg_r[s-1].m);
          nx.r2r = '0;
          stg_nxt[s] = nx;
        end
      end else if (s < PST) begin : g_root2
        // one step of the narrow square root
        localparam logic [SW-1:0] BIT2 = SW'(1) << (2 * (FRAC_BITS - (s - R20)));
        always_comb begin
          rec_t nx;
          nx = stg_r[s-1];
          if (stg_r[s-1].r2v >= stg_r[s-1].r2r + BIT2) begin
            nx.r2v = stg_r[s-1].r2v - (stg_r[s-1].r2r + BIT2);
            nx.r2r = (stg_r[s-1].r2r >> 1) + BIT2;
          end else begin
            nx.r2r = stg_r[s-1].r2r >> 1;
          end
          stg_nxt[s] = nx;
        end
      end else if (s == PST) begin : g_prod
        // c * sqrt(1 + m*m) and e * (1 - m)
        always_comb begin
          rec_t               nx;
          logic [FRAC_BITS:0] om;
          nx    = stg_r[s-1];
          om    = ONE - stg_r[s-1].m;
          nx.t1 = 64'(stg_r[s-1].c) * 64'(stg_r[s-1].r2r);
          nx.t2 = 64'(stg_r[s-1].e) * 64'(om);
          stg_nxt[s] = nx;
        end
      end else begin : g_sum
        // final sum with saturation
        always_comb begin
          rec_t        nx;
          logic [63:0] sum;
          nx  = stg_r[s-1];
          sum = (stg_r[s-1].t1 >> FRAC_BITS) + (stg_r[s-1].t2 >> FRAC_BITS)
              + 64'(stg_r[s-1].g2);
          if (!stg_r[s-1].done) begin
            nx.res = (sum >= 64'(inf_r)) ? inf_r : sum[VAL_W-1:0];
          end
          stg_nxt[s] = nx;
        end
      end
    end
  endgenerate

  // pipeline registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NST; i++) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("pipeline not empty after reset");
  a_root_le_c: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[DV0-1] |-> stg_r[DV0-1].sr <= 64'(stg_r[DV0-1].c))
    else $error("wide root exceeds cell cost");
  a_m_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[MST] |-> stg_r[MST].m <= ONE)
    else $error("ratio above one");
  a_root2_ge_one: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[PST-1] |-> stg_r[PST-1].r2r >= SW'(ONE))
    else $error("narrow root below one");
  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(vld_r))
    else $error("valid bits moved during stall");

endmodule

@@ tb/field_dstar_interpolated_cost_tb.sv @@
`timescale 1ns / 1ps

module field_dstar_interpolated_cost_tb;
  import fdic_pkg::*;

  localparam int F = 8;
  localparam int LATENCY = 42 + 2 * F;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 530;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we;
  logic [VAL_W-1:0] cfg_wdata;

  typedef struct packed {
    logic [31:0] center_cost;
    logic [31:0] adjacent_cost;
    logic [31:0] g_a;
    logic [31:0] g_b;
    logic        a_is_diagonal;
  } node_item_t;

  // one row of the directed table; has_cost means the cost is typed in
  typedef struct packed {
    logic [31:0] center_cost;
    logic [31:0] adjacent_cost;
    logic [31:0] g_a;
    logic [31:0] g_b;
    logic        a_is_diagonal;
    logic        has_cost;
    logic [31:0] cost;
  } node_row_t;

  logic [31:0] inf_code;
  logic [31:0] cost_queue[$];
  int n_fail;
  int n_mismatch;
  int n_sent;
  int n_got;
  int idle_cycles;
  logic quiet_mode;
  logic hold_out;

  field_dstar_interpolated_cost #(.FRAC_BITS(F)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // integer square root, floor
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    r = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clip_cost(input logic [63:0] v);
    return (v >= {32'd0, inf_code}) ? inf_code : v[31:0];
  endfunction

  // c * sqrt(1 + m*m) + e * (1 - m) + g2
  function automatic logic [31:0] cross_cost(input logic [63:0] c, input logic [63:0] e,
                                             input logic [63:0] m, input logic [63:0] g2);
    logic [63:0] one;
    logic [63:0] root;
    logic [63:0] t1;
    logic [63:0] t2;
    one = 64'd1 << F;
    root = floor_root((one << F) + m * m);
    t1 = (c * root) >> F;
    t2 = (e * (one - m)) >> F;
    return clip_cost(t1 + t2 + g2);
  endfunction

  function automatic logic [31:0] slope_cost(input logic [63:0] c, input logic [63:0] e,
                                             input logic [63:0] g2);
    logic [63:0] d;
    logic [63:0] m;
    d = floor_root(c * c - e * e);
    if (d == 0) d = 1;
    m = (e << F) / d;
    if (m > (64'd1 << F)) m = 64'd1 << F;
    return cross_cost(c, e, m, g2);
  endfunction

  function automatic logic [31:0] node_cost(input node_item_t it);
    logic [63:0] c;
    logic [63:0] b;
    logic [63:0] g1;
    logic [63:0] g2;
    logic [63:0] mc;
    logic [63:0] f;
    c = 64'(it.center_cost);
    b = 64'(it.adjacent_cost);
    g1 = 64'(it.a_is_diagonal ? it.g_b : it.g_a);
    g2 = 64'(it.a_is_diagonal ? it.g_a : it.g_b);
    mc = (c < b) ? c : b;
    if (mc >= {32'd0, inf_code}) return inf_code;
    if (g1 <= g2) return clip_cost(mc + g1);
    f = g1 - g2;
    if (f <= b) begin
      if (c <= f) return cross_cost(c, 64'd0, 64'd1 << F, g2);
      return slope_cost(c, f, g2);
    end
    if (c <= b) return cross_cost(c, 64'd0, 64'd1 << F, g2);
    return slope_cost(c, b, g2);
  endfunction

  // offer one item until accepted, with random idle cycles before it
  task automatic send_item(input node_item_t it, input logic has_cost, input logic [31:0] cost);
    while (!quiet_mode && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {it.g_b, it.g_a, it.adjacent_cost, it.center_cost};
    in_tuser <= it.a_is_diagonal;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cost_queue.push_back(has_cost ? cost : node_cost(it));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain_and_write(input logic [31:0] value);
    in_tvalid <= 1'b0;
    while (cost_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    inf_code = value;
  endtask

  function automatic logic [31:0] rand_value(input logic [31:0] lim);
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(255);
      2: return $urandom_range(32'hFFFF);
      3: return lim - $urandom_range(3);
      default: return $urandom_range(32'h3FFFFF);
    endcase
  endfunction

  // mostly planning-like items: costs below the blocked code, g spread near each other
  function automatic node_item_t rand_item();
    node_item_t it;
    it.center_cost = rand_value(inf_code);
    it.adjacent_cost = rand_value(inf_code);
    it.g_a = rand_value(inf_code);
    it.g_b = ($urandom_range(1)) ? it.g_a + $urandom_range(32'h3FFF) - 32'h1FFF
                                : rand_value(inf_code);
    it.a_is_diagonal = 1'($urandom_range(1));
    return it;
  endfunction

  // receiver: random stalls, a stall-free stretch and one long hold-off
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_tready <= !hold_out && (quiet_mode || $urandom_range(99) >= 32);
    end
  end

  initial begin
    hold_out = 1'b0;
    wait (n_sent > 60);
    @(negedge clk);
    hold_out = 1'b1;
    repeat (300) @(negedge clk);
    hold_out = 1'b0;
  end

  // compare each result with the oldest expected cost
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_got++;
      idle_cycles <= 0;
      if (cost_queue.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result path_cost=%h", out_tdata);
      end else begin
        logic [31:0] want;
        want = cost_queue.pop_front();
        if (out_tdata !== want) begin
          n_fail++;
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("path_cost mismatch: expected %h actual %h", want, out_tdata);
        end
      end
    end else if (rst_n && in_tvalid && in_tready) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("timeout with %0d results outstanding", cost_queue.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  node_row_t table_rows[] = '{
    // blocked at reset code
    '{32'd256000000, 32'd256000000, 32'd0, 32'd0, 1'b0, 1'b1, 32'd256000000},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 32'd256000000},
    // all zero
    '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 32'd0},
    // straight along the edge: g1 <= g2 gives min(c,b) + g1
    '{32'd256, 32'd512, 32'd100, 32'd200, 1'b0, 1'b1, 32'd356},
    '{32'd256, 32'd512, 32'd200, 32'd100, 1'b1, 1'b1, 32'd356},
    // saturation of the sum and g beyond the blocked code
    '{32'd256, 32'd256, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b1, 32'd256000000},
    // diagonal direct and interpolated cases
    '{32'd256, 32'd1024, 32'd1000, 32'd0, 1'b0, 1'b0, 32'd0},
    '{32'd1024, 32'd1024, 32'd300, 32'd0, 1'b0, 1'b0, 32'd0},
    '{32'd1024, 32'd100, 32'd900, 32'd0, 1'b1, 1'b0, 32'd0},
    '{32'd1024, 32'd100, 32'd0, 32'd900, 1'b1, 1'b0, 32'd0},
    '{32'd256, 32'd100, 32'd5000, 32'd40, 1'b0, 1'b0, 32'd0},
    '{32'd1000, 32'd999, 32'd1999, 32'd1000, 1'b0, 1'b0, 32'd0},
    '{32'hF423FFF, 32'hF423FFF, 32'hF000000, 32'd0, 1'b0, 1'b0, 32'd0},
    '{32'd1, 32'd0, 32'd5, 32'd0, 1'b0, 1'b0, 32'd0},
    '{32'd3, 32'd1, 32'd1, 32'd0, 1'b1, 1'b0, 32'd0},
    '{32'd3, 32'd3, 32'd0, 32'd2, 1'b1, 1'b0, 32'd0}
  };

  node_item_t item;
  logic [31:0] inf_settings[4] = '{32'hFFFFFFFF, 32'd0, 32'd5000, 32'h00100000};

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    n_fail = 0;
    n_mismatch = 0;
    n_sent = 0;
    n_got = 0;
    idle_cycles = 0;
    quiet_mode = 1'b0;
    inf_code = inf_reset(F);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows
    foreach (table_rows[i]) begin
      item = '{table_rows[i].center_cost, table_rows[i].adjacent_cost, table_rows[i].g_a,
               table_rows[i].g_b, table_rows[i].a_is_diagonal};
      send_item(item, table_rows[i].has_cost, table_rows[i].cost);
    end

    // random phases, each under its own blocked code
    for (int p = 0; p < 5; p++) begin
      if (p > 0) drain_and_write(inf_settings[p-1]);
      // sender pause until the pipeline is empty
      if (p == 2) while (cost_queue.size() != 0) @(negedge clk);
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        quiet_mode = (p == 1 && k >= 20 && k < 80);
        send_item(rand_item(), 1'b0, 32'd0);
      end
      quiet_mode = 1'b0;
    end
    in_tvalid <= 1'b0;

    while (cost_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    $display("%0d items sent, %0d results checked over 5 blocked-code settings", n_sent, n_got);
    $display("covered blocked, edge, diagonal and interpolated cases with stalls");
    if (n_fail == 0 && cost_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
